// File: rtl/abpw_pkg.sv
// shared types, constants and channel helpers for the alpha blend pixel writer
package abpw_pkg;

   localparam int FB_DEPTH   = 65536;
   localparam int MEM_AW     = $clog2(FB_DEPTH);

   localparam int COORD_W    = 10;
   localparam int PITCH_W    = 11;
   localparam int SHIFT_W    = 5;
   localparam int LOSS_W     = 3;
   localparam int CHAN_W     = 8;
   localparam int WORD_W     = 32;
   localparam int WADDR_W    = 16;
   localparam int ADDR_W     = COORD_W + PITCH_W;
   localparam int BLEND_W    = 2 * CHAN_W + 1;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = WADDR_W + WORD_W;

   localparam int CSR_IDX_W  = 3;

   localparam int JOBQ_DEPTH = 4;
   localparam int OUTQ_DEPTH = 8;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_PITCH   = 3'd0,
      CSR_RED_SHIFT   = 3'd1,
      CSR_GREEN_SHIFT = 3'd2,
      CSR_BLUE_SHIFT  = 3'd3,
      CSR_RED_LOSS    = 3'd4,
      CSR_GREEN_LOSS  = 3'd5,
      CSR_BLUE_LOSS   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [PITCH_W-1:0] row_pitch_words;
      logic [SHIFT_W-1:0] red_shift;
      logic [SHIFT_W-1:0] green_shift;
      logic [SHIFT_W-1:0] blue_shift;
      logic [LOSS_W-1:0]  red_loss;
      logic [LOSS_W-1:0]  green_loss;
      logic [LOSS_W-1:0]  blue_loss;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      row_pitch_words: PITCH_W'(512),
      red_shift:       SHIFT_W'(16),
      green_shift:     SHIFT_W'(8),
      blue_shift:      SHIFT_W'(0),
      red_loss:        LOSS_W'(0),
      green_loss:      LOSS_W'(0),
      blue_loss:       LOSS_W'(0)
   };

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              out_of_range;
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_alpha;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic              valid;
      job_type           job;
   } head_type;

   typedef struct packed {
      logic [WORD_W-1:0]  written_word;
      logic [WADDR_W-1:0] word_address;
      logic               out_of_range;
   } rsp_type;

   function automatic logic [CHAN_W-1:0] chan_unpack(input logic [WORD_W-1:0]  word,
                                                     input logic [SHIFT_W-1:0] shift,
                                                     input logic [LOSS_W-1:0]  loss);
      logic [WORD_W-1:0] msk;
      logic [WORD_W-1:0] fld;
      msk = (WORD_W'(8'hff) >> loss) << shift;
      fld = ((word & msk) >> shift) << loss;
      return fld[CHAN_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] chan_pack(input logic [CHAN_W-1:0]  c,
                                                   input logic [SHIFT_W-1:0] shift,
                                                   input logic [LOSS_W-1:0]  loss);
      return (WORD_W'(c) >> loss) << shift;
   endfunction

   // exact floor(v / 255) for v up to 255 * 255
   function automatic logic [CHAN_W-1:0] chan_div255(input logic [BLEND_W-1:0] v);
      logic [BLEND_W-1:0] t;
      t = v + (v >> CHAN_W) + BLEND_W'(1);
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

// File: rtl/abpw_front.sv
// front end: control registers, item decode, address and range classification
module abpw_front import abpw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PITCH_W-1:0]    csr_wdata,
   input  logic                  init_done,
   input  logic                  push_ready,
   output push_type              push,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   logic [COORD_W-1:0] pos_x, pos_y;
   logic [ADDR_W-1:0]  addr;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_PITCH:   cfg_in.row_pitch_words = csr_wdata;
            CSR_RED_SHIFT:   cfg_in.red_shift       = csr_wdata[SHIFT_W-1:0];
            CSR_GREEN_SHIFT: cfg_in.green_shift     = csr_wdata[SHIFT_W-1:0];
            CSR_BLUE_SHIFT:  cfg_in.blue_shift      = csr_wdata[SHIFT_W-1:0];
            CSR_RED_LOSS:    cfg_in.red_loss        = csr_wdata[LOSS_W-1:0];
            CSR_GREEN_LOSS:  cfg_in.green_loss      = csr_wdata[LOSS_W-1:0];
            CSR_BLUE_LOSS:   cfg_in.blue_loss       = csr_wdata[LOSS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   assign pos_x = req_tdata[COORD_W-1:0];
   assign pos_y = req_tdata[2*COORD_W-1:COORD_W];

   // 10 x 11 bit product plus column always fits the 21 bit address
   assign addr = ADDR_W'(pos_y) * ADDR_W'(cfg_ff.row_pitch_words) + ADDR_W'(pos_x);

   assign req_tready = push_ready && init_done;

   always_comb begin
      push.valid            = req_tvalid && req_tready;
      push.job.addr         = addr;
      push.job.out_of_range = addr >= ADDR_W'(FB_DEPTH);
      push.job.src_red      = req_tdata[2*COORD_W+CHAN_W-1:2*COORD_W];
      push.job.src_green    = req_tdata[2*COORD_W+2*CHAN_W-1:2*COORD_W+CHAN_W];
      push.job.src_blue     = req_tdata[2*COORD_W+3*CHAN_W-1:2*COORD_W+2*CHAN_W];
      push.job.src_alpha    = req_tdata[2*COORD_W+4*CHAN_W-1:2*COORD_W+3*CHAN_W];
   end

endmodule

// File: rtl/abpw_queue.sv
// short job queue between the front end and the blend pipeline
module abpw_queue import abpw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     push_ready,
   output head_type head,
   input  logic     pop
);

   localparam int PW = $clog2(JOBQ_DEPTH);

   job_type         slot_ff [JOBQ_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;

   assign push_ready = count_ff != (PW+1)'(JOBQ_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PW'(1);
      end
      if (push.valid && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// File: rtl/abpw_back.sv
// back end: frame store, read-modify-write blend pipeline and result queue
module abpw_back import abpw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  head_type              head,
   output logic                  pop,
   output logic                  init_done,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int OPW = $clog2(OUTQ_DEPTH);
   localparam int OCW = OPW + 1;
   localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(FB_DEPTH - 1);

   // frame store
   logic [WORD_W-1:0] mem [FB_DEPTH];
   logic [WORD_W-1:0] rdata_ff;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_wa;
   logic [WORD_W-1:0] mem_wd;

   // clearing pass
   logic              clearing_ff, clearing_in;
   logic [MEM_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // pipeline
   logic                s1_v_ff, s2_v_ff, s3_v_ff;
   job_type             s1_job_ff, s2_job_ff, s3_job_ff;
   logic [CHAN_W-1:0]   s2_dr_ff, s2_dg_ff, s2_db_ff;
   logic [CHAN_W-1:0]   s2_dr_in, s2_dg_in, s2_db_in;
   logic [BLEND_W-1:0]  s3_sr_ff, s3_sg_ff, s3_sb_ff;
   logic [BLEND_W-1:0]  s3_sr_in, s3_sg_in, s3_sb_in;
   logic [CHAN_W-1:0]   inv_alpha;
   logic [WORD_W-1:0]   dst_word;
   logic [WORD_W-1:0]   packed_word;
   logic                s3_write;

   // last write, seen by the item whose read was issued alongside it
   logic                fwd_v_ff;
   logic [MEM_AW-1:0]   fwd_addr_ff;
   logic [WORD_W-1:0]   fwd_data_ff;

   // result queue
   rsp_type             oq_ff [OUTQ_DEPTH];
   rsp_type             oq_entry;
   logic [OPW-1:0]      oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [OCW-1:0]      oq_cnt_ff, oq_cnt_in;
   logic                oq_pop;
   logic                room;
   logic                hazard;

   assign init_done = !clearing_ff;

   // reserve queue space for everything already in flight so the pipe never stalls
   assign room = (oq_cnt_ff + OCW'(s1_v_ff) + OCW'(s2_v_ff) + OCW'(s3_v_ff))
                 < OCW'(OUTQ_DEPTH);

   // items in the first two stages have not written back yet
   assign hazard = !head.job.out_of_range &&
                   ((s1_v_ff && !s1_job_ff.out_of_range && s1_job_ff.addr == head.job.addr) ||
                    (s2_v_ff && !s2_job_ff.out_of_range && s2_job_ff.addr == head.job.addr));

   assign pop = head.valid && !clearing_ff && room && !hazard;

   // stage 1: pick up the destination word and unpack it
   assign dst_word = (fwd_v_ff && fwd_addr_ff == s1_job_ff.addr[MEM_AW-1:0]) ?
                     fwd_data_ff : rdata_ff;

   always_comb begin
      s2_dr_in = chan_unpack(dst_word, cfg.red_shift,   cfg.red_loss);
      s2_dg_in = chan_unpack(dst_word, cfg.green_shift, cfg.green_loss);
      s2_db_in = chan_unpack(dst_word, cfg.blue_shift,  cfg.blue_loss);
   end

   // stage 2: weighted sums
   assign inv_alpha = CHAN_MAX - s2_job_ff.src_alpha;

   always_comb begin
      s3_sr_in = BLEND_W'(s2_job_ff.src_red)   * BLEND_W'(s2_job_ff.src_alpha)
               + BLEND_W'(s2_dr_ff) * BLEND_W'(inv_alpha);
      s3_sg_in = BLEND_W'(s2_job_ff.src_green) * BLEND_W'(s2_job_ff.src_alpha)
               + BLEND_W'(s2_dg_ff) * BLEND_W'(inv_alpha);
      s3_sb_in = BLEND_W'(s2_job_ff.src_blue)  * BLEND_W'(s2_job_ff.src_alpha)
               + BLEND_W'(s2_db_ff) * BLEND_W'(inv_alpha);
   end

   // stage 3: divide by 255, repack, write back
   assign packed_word = chan_pack(chan_div255(s3_sr_ff), cfg.red_shift,   cfg.red_loss)
                      + chan_pack(chan_div255(s3_sg_ff), cfg.green_shift, cfg.green_loss)
                      + chan_pack(chan_div255(s3_sb_ff), cfg.blue_shift,  cfg.blue_loss);

   assign s3_write = s3_v_ff && !s3_job_ff.out_of_range;

   always_comb begin
      oq_entry.word_address = s3_job_ff.addr[WADDR_W-1:0];
      oq_entry.written_word = s3_job_ff.out_of_range ? '0 : packed_word;
      oq_entry.out_of_range = s3_job_ff.out_of_range;
   end

   assign mem_we = clearing_ff || s3_write;
   assign mem_wa = clearing_ff ? clr_cnt_ff : s3_job_ff.addr[MEM_AW-1:0];
   assign mem_wd = clearing_ff ? '0 : packed_word;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (pop) begin
         rdata_ff <= mem[head.job.addr[MEM_AW-1:0]];
      end
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + MEM_AW'(1);
         if (clr_cnt_ff == CLR_LAST) begin
            clearing_in = 1'b0;
         end
      end
   end

   // result queue bookkeeping
   assign rsp_tvalid = oq_cnt_ff != '0;
   assign oq_pop     = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {oq_ff[oq_rd_ff].written_word, oq_ff[oq_rd_ff].word_address};
   assign rsp_tuser  = oq_ff[oq_rd_ff].out_of_range;

   always_comb begin
      oq_wr_in  = oq_wr_ff;
      oq_rd_in  = oq_rd_ff;
      oq_cnt_in = oq_cnt_ff;
      if (s3_v_ff) begin
         oq_wr_in = oq_wr_ff + OPW'(1);
      end
      if (oq_pop) begin
         oq_rd_in = oq_rd_ff + OPW'(1);
      end
      if (s3_v_ff && !oq_pop) begin
         oq_cnt_in = oq_cnt_ff + OCW'(1);
      end else if (oq_pop && !s3_v_ff) begin
         oq_cnt_in = oq_cnt_ff - OCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         fwd_v_ff    <= 1'b0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_cnt_ff   <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
         s1_v_ff     <= pop;
         s2_v_ff     <= s1_v_ff;
         s3_v_ff     <= s2_v_ff;
         fwd_v_ff    <= s3_write;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_cnt_ff   <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_job_ff   <= head.job;
      s2_job_ff   <= s1_job_ff;
      s3_job_ff   <= s2_job_ff;
      s2_dr_ff    <= s2_dr_in;
      s2_dg_ff    <= s2_dg_in;
      s2_db_ff    <= s2_db_in;
      s3_sr_ff    <= s3_sr_in;
      s3_sg_ff    <= s3_sg_in;
      s3_sb_ff    <= s3_sb_in;
      fwd_addr_ff <= s3_job_ff.addr[MEM_AW-1:0];
      fwd_data_ff <= packed_word;
      if (s3_v_ff) begin
         oq_ff[oq_wr_ff] <= oq_entry;
      end
   end

endmodule

// File: rtl/alpha_blend_pixel_write_top.sv
// top level of the source-over alpha blend pixel writer
//
// Each req beat carries a pixel coordinate and an RGB source color with alpha.
// The block reads the frame store word at pos_y * row_pitch_words + pos_x,
// blends source over destination per channel with (s*a + d*(255-a)) / 255,
// repacks with the programmed shifts and losses, writes the word back and
// returns one rsp beat: word address, stored word, out-of-range flag.
// An address at or past the end of the store writes nothing and returns
// a zero word with the flag set.
// A pixel moves from req accept through the job queue, the 3-stage read/blend/write
// loop around the one-read one-write frame store and the result queue to rsp valid.
// Throughput is one pixel per clock while the result queue has room; a pixel that hits
// the same word as one of the two pixels before it waits until that write-back lands.
// After reset the frame store is swept to zero, one word per cycle, through all
// FB_DEPTH (65536) words; req_tready stays low until then, while
// csr writes are taken at any time. Results wait in an 8-entry queue, so a
// stalled rsp side keeps the req side moving until that queue is reserved.
// Control registers are to be written through csr_we, csr_index, csr_wdata only
// while the block is idle, by the user; the block itself does not enforce it.
module alpha_blend_pixel_write_top import abpw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x, pos_y, src_red, src_green, src_blue, src_alpha, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // word_address, written_word
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // out_of_range
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PITCH_W-1:0]    csr_wdata
);

   cfg_type  cfg;
   push_type push;
   head_type head;
   logic     push_ready;
   logic     pop;
   logic     init_done;

   abpw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .init_done  (init_done),
      .push_ready (push_ready),
      .push       (push),
      .cfg        (cfg)
   );

   abpw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   abpw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .pop        (pop),
      .init_done  (init_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: rtl/abpw_checker.sv
// port-level checks for the alpha blend pixel writer, bound to the top level
module abpw_checker import abpw_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // a rejected address reports a zero word
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[RSP_DATA_W-1:WADDR_W] == '0)
      else $error("out of range beat carries a nonzero word");

   // reset empties the result side and starts the store sweep
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block not idle after reset");

   // no pixel is taken while still in reset
   a_no_accept_in_reset: assert property (@(posedge clock)
      $past(reset) && reset |-> !(req_tvalid && req_tready))
      else $error("req beat accepted during reset");

endmodule

bind alpha_blend_pixel_write_top abpw_checker u_abpw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
